[src/dlr_pkg.sv]
// dlr_pkg: shared constants, types and state codes of the dashed line rasterizer.
// No dependencies; every module of the block imports it.
`default_nettype none

package dlr_pkg;

  // Coordinate and dash widths
  localparam int COORD_BITS  = 6;
  localparam int PERIOD_BITS = 8;
  // Error term: range of about +/- 2 * 2^COORD_BITS, plus a sign bit
  localparam int ERR_BITS    = COORD_BITS + 3;

  // Segment queue between front and back
  localparam int Q_DEPTH     = 2;
  localparam int Q_PTR_BITS  = $clog2(Q_DEPTH);
  localparam int Q_CNT_BITS  = $clog2(Q_DEPTH + 1);

  typedef logic [COORD_BITS-1:0]  coord_t;
  typedef logic [PERIOD_BITS-1:0] period_t;
  typedef logic signed [ERR_BITS-1:0] err_t;

  // One classified segment, ready to walk
  typedef struct packed {
    coord_t  x;
    coord_t  y;
    coord_t  xe;
    coord_t  ye;
    err_t    dx;          // |xe - x|, zero or positive
    err_t    dy;          // -|ye - y|, zero or negative
    logic    step_x_neg;  // x walks downward
    logic    step_y_neg;  // y walks downward
    err_t    err;         // initial error dx + dy
    period_t period;      // dash period, zero already mapped to one
  } seg_t;

  // Queue fill status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Back-end walker states
  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } walk_state_t;

endpackage

`default_nettype wire

[src/dlr_front.sv]
// dlr_front: input handshake and segment setup (deltas, step signs, initial error).
// Depends on dlr_pkg; feeds dlr_queue.
`default_nettype none

module dlr_front
  import dlr_pkg::*;
(
  input  wire logic      start,
  output logic           busy,
  input  wire coord_t    in_start_x,
  input  wire coord_t    in_start_y,
  input  wire coord_t    in_end_x,
  input  wire coord_t    in_end_y,
  input  wire period_t   in_dash_period,
  input  wire q_status_t q_status,
  output logic           push,
  output seg_t           push_seg
);

  coord_t adx;
  coord_t ady;

  // Handshake: a transaction lands whenever the queue has room
  assign busy = q_status.full;
  assign push = start && !q_status.full;

  // Absolute deltas
  always_comb begin
    adx = (in_end_x > in_start_x) ? (in_end_x - in_start_x) : (in_start_x - in_end_x);
    ady = (in_end_y > in_start_y) ? (in_end_y - in_start_y) : (in_start_y - in_end_y);
  end

  // Classified segment
  always_comb begin
    push_seg.x          = in_start_x;
    push_seg.y          = in_start_y;
    push_seg.xe         = in_end_x;
    push_seg.ye         = in_end_y;
    push_seg.dx         = signed'({{(ERR_BITS-COORD_BITS){1'b0}}, adx});
    push_seg.dy         = -signed'({{(ERR_BITS-COORD_BITS){1'b0}}, ady});
    push_seg.step_x_neg = !(in_start_x < in_end_x);
    push_seg.step_y_neg = !(in_start_y < in_end_y);
    push_seg.err        = push_seg.dx + push_seg.dy;
    push_seg.period     = (in_dash_period == '0) ? period_t'(1) : in_dash_period;
  end

endmodule

`default_nettype wire

[src/dlr_queue.sv]
// dlr_queue: short FIFO of classified segments between front and back.
// Depends on dlr_pkg.
`default_nettype none

module dlr_queue
  import dlr_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire seg_t  push_seg,
  input  wire logic  pop,
  output seg_t       pop_seg,
  output q_status_t  status
);

  seg_t                  entry_r [Q_DEPTH];
  logic [Q_PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_BITS-1:0] count_r, count_nxt;

  // Pointer wrap at the queue depth
  function automatic logic [Q_PTR_BITS-1:0] ptr_inc(input logic [Q_PTR_BITS-1:0] p);
    ptr_inc = (p == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0 : p + Q_PTR_BITS'(1);
  endfunction

  assign status.full  = (count_r == Q_CNT_BITS'(Q_DEPTH));
  assign status.empty = (count_r == '0);
  assign pop_seg      = entry_r[rd_ptr_r];

  // Next pointers and fill count
  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop  ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + Q_CNT_BITS'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - Q_CNT_BITS'(1);
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_seg;
    end
  end

endmodule

`default_nettype wire

[src/dlr_back.sv]
// dlr_back: Bresenham walker, one pixel per cycle, with dash counter.
// Depends on dlr_pkg; drains dlr_queue.
`default_nettype none

module dlr_back
  import dlr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire q_status_t q_status,
  input  wire seg_t      pop_seg,
  output logic           pop,
  output logic           out_valid,
  output coord_t         out_pixel_x,
  output coord_t         out_pixel_y,
  output logic           out_pixel_on,
  output logic           out_last_pixel
);

  walk_state_t state_r, state_nxt;

  coord_t  x_r, y_r, xe_r, ye_r;
  err_t    dx_r, dy_r, err_r, err_nxt;
  logic    sxn_r, syn_r;
  period_t period_r;
  period_t cnt_r, cnt_nxt;

  logic                       done;
  logic signed [ERR_BITS:0]   twice;
  logic                       go_x, go_y;
  logic [PERIOD_BITS:0]       cnt_inc;

  assign done = (x_r == xe_r) && (y_r == ye_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (!q_status.empty) state_nxt = ST_RUN;
      ST_RUN:  if (done && q_status.empty) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the state machine
  always_comb begin
    pop       = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: pop = !q_status.empty;
      ST_RUN: begin
        out_valid = 1'b1;
        pop       = done && !q_status.empty;
      end
      default: pop = 1'b0;
    endcase
  end

  assign out_pixel_x    = x_r;
  assign out_pixel_y    = y_r;
  assign out_pixel_on   = (cnt_r == '0);
  assign out_last_pixel = done;

  // Bresenham error step, compares are signed
  always_comb begin
    twice   = {err_r, 1'b0};
    go_x    = (twice >= signed'({dy_r[ERR_BITS-1], dy_r}));
    go_y    = (twice <= signed'({dx_r[ERR_BITS-1], dx_r}));
    err_nxt = err_r + (go_x ? dy_r : err_t'(0)) + (go_y ? dx_r : err_t'(0));
  end

  // Dash counter: step index modulo the period
  always_comb begin
    cnt_inc = {1'b0, cnt_r} + (PERIOD_BITS + 1)'(1);
    cnt_nxt = (cnt_inc == {1'b0, period_r}) ? '0 : cnt_inc[PERIOD_BITS-1:0];
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Walker datapath: load a segment or take one step
  always_ff @(posedge clk) begin
    if (pop) begin
      x_r      <= pop_seg.x;
      y_r      <= pop_seg.y;
      xe_r     <= pop_seg.xe;
      ye_r     <= pop_seg.ye;
      dx_r     <= pop_seg.dx;
      dy_r     <= pop_seg.dy;
      sxn_r    <= pop_seg.step_x_neg;
      syn_r    <= pop_seg.step_y_neg;
      err_r    <= pop_seg.err;
      period_r <= pop_seg.period;
      cnt_r    <= '0;
    end else if (state_r == ST_RUN) begin
      if (go_x) x_r <= sxn_r ? x_r - coord_t'(1) : x_r + coord_t'(1);
      if (go_y) y_r <= syn_r ? y_r - coord_t'(1) : y_r + coord_t'(1);
      err_r <= err_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

[src/dashed_line_rasterizer_unit.sv]
// dashed_line_rasterizer_unit: top level, segment setup, queue and pixel walker.
// Depends on dlr_pkg, dlr_front, dlr_queue, dlr_back.
//
//  channel  | ports                                        | flow control
//  ---------+----------------------------------------------+------------------------
//  input    | start, busy, in_start_x/y, in_end_x/y,       | taken when start && !busy
//           | in_dash_period                               |
//  result   | out_valid, out_pixel_x/y, out_pixel_on,      | one-cycle strobe, no stall
//           | out_last_pixel                               |
//
// A segment yields max(|dx|,|dy|)+1 pixels, up to 64, one per cycle from the walker in
// dlr_back. With the walker idle, an accepted segment is written into the queue, then
// loaded into the walker registers, and its first pixel then appears on the ports;
// queued segments follow with no gap.
// busy is high while the two-entry segment queue is full.
// Synchronous active-low reset empties the queue and idles the walker.
`default_nettype none

module dashed_line_rasterizer_unit
  import dlr_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  output logic         busy,
  input  wire coord_t  in_start_x,
  input  wire coord_t  in_start_y,
  input  wire coord_t  in_end_x,
  input  wire coord_t  in_end_y,
  input  wire period_t in_dash_period,
  output logic         out_valid,
  output coord_t       out_pixel_x,
  output coord_t       out_pixel_y,
  output logic         out_pixel_on,
  output logic         out_last_pixel
);

  q_status_t q_status;
  logic      push, pop;
  seg_t      push_seg, pop_seg;

  // Front: handshake and segment setup
  dlr_front u_front (
    .start          (start),
    .busy           (busy),
    .in_start_x     (in_start_x),
    .in_start_y     (in_start_y),
    .in_end_x       (in_end_x),
    .in_end_y       (in_end_y),
    .in_dash_period (in_dash_period),
    .q_status       (q_status),
    .push           (push),
    .push_seg       (push_seg)
  );

  // Segment queue
  dlr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_seg (push_seg),
    .pop      (pop),
    .pop_seg  (pop_seg),
    .status   (q_status)
  );

  // Back: pixel walker
  dlr_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_status       (q_status),
    .pop_seg        (pop_seg),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_pixel_x    (out_pixel_x),
    .out_pixel_y    (out_pixel_y),
    .out_pixel_on   (out_pixel_on),
    .out_last_pixel (out_last_pixel)
  );

endmodule

`default_nettype wire

[src/dlr_checker.sv]
// dlr_checker: port-level assertions for dashed_line_rasterizer_unit, plus its bind.
// Depends on dlr_pkg.
`default_nettype none

module dlr_checker
  import dlr_pkg::*;
(
  input wire logic    clk,
  input wire logic    rst_n,
  input wire logic    start,
  input wire logic    busy,
  input wire coord_t  in_start_x,
  input wire coord_t  in_start_y,
  input wire coord_t  in_end_x,
  input wire coord_t  in_end_y,
  input wire period_t in_dash_period,
  input wire logic    out_valid,
  input wire coord_t  out_pixel_x,
  input wire coord_t  out_pixel_y,
  input wire logic    out_pixel_on,
  input wire logic    out_last_pixel
);

  // Marks that the next strobe opens a new segment
  logic   first_r;
  coord_t prev_x_r, prev_y_r;
  coord_t step_x, step_y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= 1'b1;
    end else if (out_valid) begin
      first_r <= out_last_pixel;
    end
  end

  // Pixel of the previous cycle
  always_ff @(posedge clk) begin
    prev_x_r <= out_pixel_x;
    prev_y_r <= out_pixel_y;
  end

  assign step_x = out_pixel_x - prev_x_r;
  assign step_y = out_pixel_y - prev_y_r;

  // The start point of every segment is lit
  a_first_lit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && first_r |-> out_pixel_on)
    else $error("first pixel of a segment not lit");

  // Pixels of one segment come without gaps
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_pixel |=> out_valid)
    else $error("gap inside a segment");

  // Consecutive pixels of one segment are neighbors and differ
  a_neighbor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_pixel |=>
      (step_x == '0 || step_x == coord_t'(1) || step_x == '1) &&
      (step_y == '0 || step_y == coord_t'(1) || step_y == '1) &&
      !(step_x == '0 && step_y == '0))
    else $error("pixel step is not to a neighbor");

  // Leaving reset: no strobe, not busy
  a_reset_idle: assert property (@(posedge clk)
    $past(!rst_n) && rst_n |-> !out_valid && !busy)
    else $error("activity right after reset");

  // Fields of an accepted transaction are known
  a_start_known: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> !$isunknown({in_start_x, in_start_y,
      in_end_x, in_end_y, in_dash_period}))
    else $error("unknown segment fields");

endmodule

bind dashed_line_rasterizer_unit dlr_checker u_dlr_checker (.*);

`default_nettype wire
